>>> rtl/prgc_pkg.sv
// Package for the pair ranking block: key layout, key type and key builder.
// No dependencies; imported by prgc_key_cmp and pair_rank_by_global_count_and_pt.
`timescale 1ns / 1ps

package prgc_pkg;

    localparam int PT_W   = 24;            // pair pt, 1/256 GeV
    localparam int GCNT_W = 2;             // global daughter count, 0..2
    localparam int KEY_W  = GCNT_W + PT_W;
    localparam int OUT_W  = 6;             // pair_index and rank result width

    typedef logic [KEY_W-1:0] t_key;

    // count in the top bits, pt below
    function automatic t_key make_key(input logic flag_a, input logic flag_b,
                                      input logic [PT_W-1:0] pt);
        logic [GCNT_W-1:0] cnt;
        cnt = {1'b0, flag_a} + {1'b0, flag_b};
        return {cnt, pt};
    endfunction

endpackage

>>> rtl/prgc_key_cmp.sv
// Shared key comparator: says whether pair j ranks ahead of pair i.
// Depends on prgc_pkg (t_key).
`timescale 1ns / 1ps

module prgc_key_cmp #(
    parameter int IDX_W = 6
) (
    input  prgc_pkg::t_key   i_key_i,
    input  prgc_pkg::t_key   i_key_j,
    input  logic [IDX_W-1:0] i_idx_i,
    input  logic [IDX_W-1:0] i_idx_j,
    output logic             o_ahead
);
    import prgc_pkg::*;

    // ties go to the lower pair index
    assign o_ahead = (i_key_j > i_key_i) || ((i_key_j == i_key_i) && (i_idx_j < i_idx_i));

endmodule

>>> rtl/pair_rank_by_global_count_and_pt.sv
// Top level of the pair ranking block: flag table, key store, sequencer.
// Depends on prgc_pkg and prgc_key_cmp.
//
//  channel   direction  handshake             payload
//  command   in         start && !busy        i_mode, i_muon_index, i_is_global, i_pair_pt,
//                                             i_first_daughter, i_second_daughter, i_last_pair
//  result    out        o_valid, one cycle    o_pair_index, o_rank, o_last_out
//
// A flag write is done on acceptance; a pair reads the flag table, then writes its key.
// On the last pair the run emits n results; each steps ST_RDI, ST_LDI, then ST_CMP
// against every stored pair in turn, as one key store read port feeds one comparator.
// Synchronous active-low reset clears the sequencer, pair count and result strobe.
// busy is high through the whole pair and ranking sequence; results cannot be stalled.
`timescale 1ns / 1ps

module pair_rank_by_global_count_and_pt #(
    parameter int MAX_PAIRS = 64,
    parameter int MAX_MUONS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_mode,
    input  logic [7:0]                 i_muon_index,
    input  logic                       i_is_global,
    input  logic [prgc_pkg::PT_W-1:0]  i_pair_pt,
    input  logic [7:0]                 i_first_daughter,
    input  logic [7:0]                 i_second_daughter,
    input  logic                       i_last_pair,
    output logic                       o_valid,
    output logic [prgc_pkg::OUT_W-1:0] o_pair_index,
    output logic [prgc_pkg::OUT_W-1:0] o_rank,
    output logic                       o_last_out
);
    import prgc_pkg::*;

    localparam int PAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int MAW = $clog2(MAX_MUONS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEY  = 3'd1;
    localparam logic [2:0] ST_RDI  = 3'd2;
    localparam logic [2:0] ST_LDI  = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [PAW-1:0]   r_i, n_i;
    logic [PAW-1:0]   r_j, n_j;
    logic [OUT_W-1:0] r_rank, n_rank;
    t_key             r_ki, n_ki;
    logic [PT_W-1:0]  r_pt;
    logic             r_last;
    logic             r_in_a, r_in_b;
    logic             r_fa, r_fb;
    logic             r_valid, n_valid;
    logic [OUT_W-1:0] r_o_idx, n_o_idx;
    logic [OUT_W-1:0] r_o_rank, n_o_rank;
    logic             r_o_last, n_o_last;

    logic             flag_mem [MAX_MUONS];
    t_key             key_mem  [MAX_PAIRS];
    t_key             r_kq;

    logic             accept;
    logic             flag_we;
    logic             key_we;
    logic [PAW-1:0]   key_ra;
    logic [PAW-1:0]   last_idx;
    logic             ahead;

    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign flag_we  = accept && !i_mode && ({1'b0, i_muon_index} < 9'(MAX_MUONS));
    assign key_we   = (r_state == ST_KEY) && (r_cnt < CW'(MAX_PAIRS));
    assign last_idx = PAW'(r_cnt - 1'b1);

    // flag table: one write port, two registered read ports for the daughters
    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            flag_mem[i_muon_index[MAW-1:0]] <= i_is_global;
        end
        r_fa <= flag_mem[i_first_daughter[MAW-1:0]];
        r_fb <= flag_mem[i_second_daughter[MAW-1:0]];
    end

    // key store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[r_cnt[PAW-1:0]] <= make_key(r_fa && r_in_a, r_fb && r_in_b, r_pt);
        end
        r_kq <= key_mem[key_ra];
    end

    always_comb begin
        case (r_state)
            ST_RDI:  key_ra = r_i;
            ST_CMP:  key_ra = r_j + 1'b1;
            default: key_ra = '0;
        endcase
    end

    prgc_key_cmp #(
        .IDX_W (PAW)
    ) u_cmp (
        .i_key_i (r_ki),
        .i_key_j (r_kq),
        .i_idx_i (r_i),
        .i_idx_j (r_j),
        .o_ahead (ahead)
    );

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_j      = r_j;
        n_rank   = r_rank;
        n_ki     = r_ki;
        n_valid  = 1'b0;
        n_o_idx  = r_o_idx;
        n_o_rank = r_o_rank;
        n_o_last = r_o_last;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_mode) begin
                    n_state = ST_KEY;
                end
            end
            ST_KEY: begin
                if (key_we) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_last) begin
                    n_i     = '0;
                    n_state = ST_RDI;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RDI: begin
                n_state = ST_LDI;
            end
            ST_LDI: begin
                n_ki    = r_kq;
                n_j     = '0;
                n_rank  = '0;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_rank = r_rank + OUT_W'(ahead);
                n_j    = r_j + 1'b1;
                if (r_j == last_idx) begin
                    n_valid  = 1'b1;
                    n_o_idx  = OUT_W'(r_i);
                    n_o_rank = r_rank + OUT_W'(ahead);
                    n_o_last = (r_i == last_idx);
                    if (r_i == last_idx) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_RDI;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_rank   <= n_rank;
        r_ki     <= n_ki;
        r_o_idx  <= n_o_idx;
        r_o_rank <= n_o_rank;
        r_o_last <= n_o_last;
        if (accept && i_mode) begin
            r_pt   <= i_pair_pt;
            r_last <= i_last_pair;
            // out-of-range daughters count as not global
            r_in_a <= ({1'b0, i_first_daughter} < 9'(MAX_MUONS));
            r_in_b <= ({1'b0, i_second_daughter} < 9'(MAX_MUONS));
        end
    end

    assign o_valid      = r_valid;
    assign o_pair_index = r_o_idx;
    assign o_rank       = r_o_rank;
    assign o_last_out   = r_o_last;

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_out) |-> !busy)
        else $error("last result while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_out) |-> busy)
        else $error("run ended without a last result");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results on adjacent cycles");

    a_j_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (CW'(r_j) < r_cnt))
        else $error("compare index beyond pair count");

    a_pair_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode) |=> busy)
        else $error("pair transaction did not raise busy");

endmodule
